// ===== src/sls_pkg.sv =====
package sls_pkg;

  localparam int unsigned AddrW  = 64;
  localparam int unsigned CountW = 32;
  localparam int unsigned SumW   = 64;

  typedef enum logic [1:0] {
    CLS_LINEAR  = 2'd0,
    CLS_MONO    = 2'd1,
    CLS_OVERLAP = 2'd2,
    CLS_NONMONO = 2'd3
  } cls_t;

  typedef struct packed {
    logic              at_first;
    logic              classify_done;
    logic              no_overlap_seen;
    logic [AddrW-1:0]  prev_start;
    logic [CountW-1:0] prev_count;
    logic [AddrW-1:0]  low_mark;
    logic [AddrW-1:0]  high_mark;
    logic [SumW-1:0]   running_sum;
    cls_t              cls;
  } scan_state_t;

  typedef struct packed {
    cls_t             linearity_class;
    logic [SumW-1:0]  total_blocks;
    logic [AddrW-1:0] lowest_block;
    logic [AddrW-1:0] end_block_plus_one;
    logic             sum_is_hard;
  } result_t;

  localparam scan_state_t ScanReset = '{
    at_first:        1'b1,
    classify_done:   1'b0,
    no_overlap_seen: 1'b1,
    prev_start:      '0,
    prev_count:      '0,
    low_mark:        '0,
    high_mark:       '0,
    running_sum:     '0,
    cls:             CLS_LINEAR
  };

  function automatic cls_t weaken(cls_t cur, cls_t cand);
    return (cand > cur) ? cand : cur;
  endfunction

endpackage

// ===== src/sgl_linearity_scan_core.sv =====
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_stall   | start_block, block_count, last_elem
// out_    | output    | out_valid/out_stall | class, total, lowest, end+1, sum_is_hard
//
// one element per cycle sustained while in_stall is low; a result for a list passes from
// the input register through the list update into the result register, where out_valid
// offers it until out_stall is low
// the list state updates in the same cycle the element leaves the input register
// rst_n is synchronous and returns the scan to the start of a new list
// out_stall holds only the final element of a list; other elements keep flowing
module sgl_linearity_scan_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sls_pkg::AddrW-1:0]   in_start_block,
  input  logic [sls_pkg::CountW-1:0]  in_block_count,
  input  logic                        in_last_elem,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_linearity_class,
  output logic [sls_pkg::SumW-1:0]    out_total_blocks,
  output logic [sls_pkg::AddrW-1:0]   out_lowest_block,
  output logic [sls_pkg::AddrW-1:0]   out_end_block_plus_one,
  output logic                        out_sum_is_hard
);

  logic                       s1_valid_r;
  logic [sls_pkg::AddrW-1:0]  s1_start_r;
  logic [sls_pkg::CountW-1:0] s1_count_r;
  logic                       s1_last_r;
  logic                       s1_go;
  logic                       res_load;
  logic                       can_load;
  sls_pkg::scan_state_t       st_r;
  sls_pkg::scan_state_t       st_nxt;
  sls_pkg::result_t           res;

  assign s1_go    = s1_valid_r && (!s1_last_r || can_load);
  assign res_load = s1_valid_r && s1_last_r;
  assign in_stall = s1_valid_r && !s1_go;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_start_r <= in_start_block;
      s1_count_r <= in_block_count;
      s1_last_r  <= in_last_elem;
    end
  end

  // list state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= sls_pkg::ScanReset;
    end else if (s1_go) begin
      st_r <= s1_last_r ? sls_pkg::ScanReset : st_nxt;
    end
  end

  sls_update u_update (
    .st          (st_r),
    .start_block (s1_start_r),
    .block_count (s1_count_r),
    .st_nxt      (st_nxt),
    .res         (res)
  );

  sls_result_reg u_result (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .load                   (res_load),
    .res                    (res),
    .can_load               (can_load),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_linearity_class    (out_linearity_class),
    .out_total_blocks       (out_total_blocks),
    .out_lowest_block       (out_lowest_block),
    .out_end_block_plus_one (out_end_block_plus_one),
    .out_sum_is_hard        (out_sum_is_hard)
  );

  a_last_makes_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_last_r) |=> out_valid)
    else $error("last element did not produce a result");

  a_last_resets_state: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_last_r) |=> (st_r.at_first && !st_r.classify_done))
    else $error("scan state not cleared after last element");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_last_r && out_valid))
    else $error("input stalled without a pending result");

  a_done_is_weak: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.classify_done |->
      (st_r.cls == sls_pkg::CLS_OVERLAP || st_r.cls == sls_pkg::CLS_NONMONO))
    else $error("classification stopped with a strong class");

endmodule

// ===== src/sls_update.sv =====
module sls_update (
  input  sls_pkg::scan_state_t         st,
  input  logic [sls_pkg::AddrW-1:0]    start_block,
  input  logic [sls_pkg::CountW-1:0]   block_count,
  output sls_pkg::scan_state_t         st_nxt,
  output sls_pkg::result_t             res
);

  logic                       degen;
  logic [sls_pkg::AddrW-1:0]  elem_end;
  logic [sls_pkg::AddrW-1:0]  prev_end;
  logic [sls_pkg::AddrW-1:0]  high_upd;
  logic [sls_pkg::SumW-1:0]   sum_upd;
  logic                       same_start;
  logic                       below_prev;
  sls_pkg::cls_t              cls_fin;

  assign degen      = (block_count == '0);
  assign elem_end   = start_block + sls_pkg::AddrW'(block_count);
  assign prev_end   = st.prev_start + sls_pkg::AddrW'(st.prev_count);
  assign high_upd   = (elem_end > st.high_mark) ? elem_end : st.high_mark;
  assign sum_upd    = st.running_sum + sls_pkg::SumW'(block_count);
  assign same_start = (st.prev_start == start_block);
  assign below_prev = (st.prev_start > start_block);

  always_comb begin
    st_nxt = st;
    if (st.at_first) begin
      st_nxt.at_first    = 1'b0;
      st_nxt.low_mark    = start_block;
      st_nxt.running_sum = sls_pkg::SumW'(block_count);
      st_nxt.high_mark   = elem_end;
      st_nxt.prev_start  = start_block;
      st_nxt.prev_count  = block_count;
    end else if (!degen) begin
      st_nxt.running_sum = sum_upd;
      st_nxt.high_mark   = high_upd;
      st_nxt.prev_start  = start_block;
      if (!st.classify_done) begin
        if (prev_end != start_block) begin
          st_nxt.cls = sls_pkg::weaken(st.cls, sls_pkg::CLS_MONO);
        end
        if (same_start && (st.prev_count != '0)) begin
          st_nxt.cls           = sls_pkg::weaken(st_nxt.cls, sls_pkg::CLS_OVERLAP);
          st_nxt.classify_done = 1'b1;
        end else if (below_prev) begin
          st_nxt.low_mark      = start_block;
          st_nxt.cls           = sls_pkg::CLS_NONMONO;
          st_nxt.classify_done = 1'b1;
        end else begin
          if (prev_end > start_block) begin
            st_nxt.no_overlap_seen = 1'b0;
          end
          st_nxt.prev_count = block_count;
        end
      end else begin
        if (below_prev && (start_block < st.low_mark)) begin
          st_nxt.low_mark = start_block;
        end
      end
    end
  end

  always_comb begin
    cls_fin = st_nxt.cls;
    if (!st_nxt.classify_done && !st_nxt.no_overlap_seen) begin
      cls_fin = sls_pkg::weaken(st_nxt.cls, sls_pkg::CLS_OVERLAP);
    end
    res.linearity_class = cls_fin;
    res.total_blocks    = st_nxt.running_sum;
    res.lowest_block    = st_nxt.low_mark;
    if (degen && (start_block > st_nxt.high_mark)) begin
      res.end_block_plus_one = start_block;
    end else begin
      res.end_block_plus_one = st_nxt.high_mark;
    end
    res.sum_is_hard = !degen;
  end

endmodule

// ===== src/sls_result_reg.sv =====
module sls_result_reg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  sls_pkg::result_t            res,
  output logic                        can_load,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_linearity_class,
  output logic [sls_pkg::SumW-1:0]    out_total_blocks,
  output logic [sls_pkg::AddrW-1:0]   out_lowest_block,
  output logic [sls_pkg::AddrW-1:0]   out_end_block_plus_one,
  output logic                        out_sum_is_hard
);

  logic             valid_r;
  sls_pkg::result_t res_r;

  assign can_load = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      res_r <= res;
    end
  end

  assign out_valid              = valid_r;
  assign out_linearity_class    = res_r.linearity_class;
  assign out_total_blocks       = res_r.total_blocks;
  assign out_lowest_block       = res_r.lowest_block;
  assign out_end_block_plus_one = res_r.end_block_plus_one;
  assign out_sum_is_hard        = res_r.sum_is_hard;

endmodule

// ===== bench/sgl_linearity_scan_core_test.sv =====
`timescale 1ns / 1ps

module sgl_linearity_scan_core_test;

  localparam int CycleLimit = 400000;
  localparam int PlanLen = 24;
  localparam int RandomItems = 1025;
  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam sls_pkg::result_t NoCheck = '0;

  typedef struct packed {
    logic [63:0]      start;
    logic [31:0]      count;
    logic             last;
    logic             typed;
    sls_pkg::result_t want;
  } stim_row_t;

  typedef enum int {NEXT_ABUTS, NEXT_GAP, NEXT_SAME, NEXT_INSIDE, NEXT_BELOW, NEXT_ANY}
    next_start_t;
  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PULSED} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_start_block = '0;
  logic [31:0] in_block_count = '0;
  logic        in_last_elem = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_linearity_class;
  logic [63:0] out_total_blocks;
  logic [63:0] out_lowest_block;
  logic [63:0] out_end_block_plus_one;
  logic        out_sum_is_hard;

  sgl_linearity_scan_core uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_start_block         (in_start_block),
    .in_block_count         (in_block_count),
    .in_last_elem           (in_last_elem),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_linearity_class    (out_linearity_class),
    .out_total_blocks       (out_total_blocks),
    .out_lowest_block       (out_lowest_block),
    .out_end_block_plus_one (out_end_block_plus_one),
    .out_sum_is_hard        (out_sum_is_hard)
  );

  always #6 clk = ~clk;

  // list summary predictor state
  logic          lst_first;
  logic          lst_frozen;
  logic          lst_disjoint;
  logic [63:0]   lst_prev_start;
  logic [31:0]   lst_prev_count;
  logic [63:0]   lst_low;
  logic [63:0]   lst_high;
  logic [63:0]   lst_sum;
  sls_pkg::cls_t lst_cls;

  sls_pkg::result_t pending_results[$];
  sls_pkg::result_t oldest;
  int          mismatches = 0;
  int          cycles = 0;
  int          burst_left = 0;
  logic        in_took = 1'b0;
  rx_mode_t    rx_mode = RX_OPEN;
  int          rx_left = 0;

  stim_row_t plan [PlanLen] = '{
    '{64'd0, 32'd0, 1'b1, 1'b1, '{sls_pkg::CLS_LINEAR, 64'd0, 64'd0, 64'd0, 1'b0}},
    '{AllOnes, 32'hFFFF_FFFF, 1'b1, 1'b1,
      '{sls_pkg::CLS_LINEAR, 64'hFFFF_FFFF, AllOnes, 64'hFFFF_FFFE, 1'b1}},
    '{AllOnes, 32'd0, 1'b1, 1'b1,
      '{sls_pkg::CLS_LINEAR, 64'd0, AllOnes, AllOnes, 1'b0}},
    '{64'd0, 32'hFFFF_FFFF, 1'b1, 1'b1,
      '{sls_pkg::CLS_LINEAR, 64'hFFFF_FFFF, 64'd0, 64'hFFFF_FFFF, 1'b1}},
    // contiguous list
    '{64'd100, 32'd8, 1'b0, 1'b0, NoCheck},
    '{64'd108, 32'd8, 1'b0, 1'b0, NoCheck},
    '{64'd116, 32'd4, 1'b1, 1'b0, NoCheck},
    // gap, skipped zero count, trailing zero count past the end
    '{64'd1000, 32'd16, 1'b0, 1'b0, NoCheck},
    '{64'd5, 32'd0, 1'b0, 1'b0, NoCheck},
    '{64'd2000, 32'd16, 1'b0, 1'b0, NoCheck},
    '{64'd9000, 32'd0, 1'b1, 1'b0, NoCheck},
    // same start stops classifying, later element lowers the low mark
    '{64'd500, 32'd10, 1'b0, 1'b0, NoCheck},
    '{64'd500, 32'd20, 1'b0, 1'b0, NoCheck},
    '{64'd300, 32'd5, 1'b0, 1'b0, NoCheck},
    '{64'd400, 32'd1, 1'b1, 1'b0, NoCheck},
    // partial overlap
    '{64'd50, 32'd10, 1'b0, 1'b0, NoCheck},
    '{64'd55, 32'd10, 1'b1, 1'b0, NoCheck},
    // decrease, trailing zero count below the end
    '{64'd70, 32'd10, 1'b0, 1'b0, NoCheck},
    '{64'd20, 32'd5, 1'b0, 1'b0, NoCheck},
    '{64'd10, 32'd0, 1'b1, 1'b0, NoCheck},
    // zero count first element, then same start
    '{64'd42, 32'd0, 1'b0, 1'b0, NoCheck},
    '{64'd42, 32'd7, 1'b1, 1'b0, NoCheck},
    // end address wraps
    '{64'hFFFF_FFFF_FFFF_FFF0, 32'd32, 1'b0, 1'b0, NoCheck},
    '{64'h10, 32'hFFFF_FFFF, 1'b1, 1'b0, NoCheck}
  };

  function automatic void clear_scan();
    lst_first      = 1'b1;
    lst_frozen     = 1'b0;
    lst_disjoint   = 1'b1;
    lst_prev_start = '0;
    lst_prev_count = '0;
    lst_low        = '0;
    lst_high       = '0;
    lst_sum        = '0;
    lst_cls        = sls_pkg::CLS_LINEAR;
  endfunction

  function automatic void demote(sls_pkg::cls_t to);
    if (to > lst_cls) lst_cls = to;
  endfunction

  function automatic bit scan_element(input logic [63:0] s, input logic [31:0] c,
                                      input logic last, output sls_pkg::result_t r);
    logic [63:0] elem_end;
    logic [63:0] prev_end;
    logic        degen;
    logic        halt;
    degen    = (c == '0);
    elem_end = s + 64'(c);
    prev_end = lst_prev_start + 64'(lst_prev_count);
    halt     = 1'b0;
    r        = '0;
    if (lst_first) begin
      lst_low        = s;
      lst_sum        = 64'(c);
      lst_high       = elem_end;
      lst_first      = 1'b0;
      lst_prev_start = s;
      lst_prev_count = c;
    end else if (!degen) begin
      lst_sum = lst_sum + 64'(c);
      if (elem_end > lst_high) lst_high = elem_end;
      if (!lst_frozen) begin
        if (prev_end != s) demote(sls_pkg::CLS_MONO);
        if (lst_prev_start == s) begin
          if (lst_prev_count != '0) begin
            demote(sls_pkg::CLS_OVERLAP);
            halt = 1'b1;
          end
        end else if (lst_prev_start > s) begin
          lst_low = s;
          demote(sls_pkg::CLS_NONMONO);
          halt = 1'b1;
        end
        if (halt) begin
          lst_frozen = 1'b1;
        end else begin
          if (prev_end > s) lst_disjoint = 1'b0;
          lst_prev_count = c;
        end
      end else if (lst_prev_start > s && s < lst_low) begin
        lst_low = s;
      end
      lst_prev_start = s;
    end
    if (!last) return 1'b0;
    if (!lst_frozen && !lst_disjoint) demote(sls_pkg::CLS_OVERLAP);
    r.linearity_class    = lst_cls;
    r.total_blocks       = lst_sum;
    r.lowest_block       = lst_low;
    r.end_block_plus_one = (degen && s > lst_high) ? s : lst_high;
    r.sum_is_hard        = !degen;
    clear_scan();
    return 1'b1;
  endfunction

  task automatic send_element(input logic [63:0] s, input logic [31:0] c, input logic last,
                              input logic typed, input sls_pkg::result_t want);
    sls_pkg::result_t got;
    int               gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_start_block <= s;
    in_block_count <= c;
    in_last_elem   <= last;
    do @(negedge clk); while (!in_took);
    if (scan_element(s, c, last, got)) begin
      pending_results.insert(pending_results.size(), typed ? want : got);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] seen);
    if (seen !== want) begin
      $display("%0t: %s expected %h actual %h", $time, what, want, seen);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction, class %0d total %h", $time,
                 out_linearity_class, out_total_blocks);
        mismatches++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("linearity_class", 64'(oldest.linearity_class), 64'(out_linearity_class));
        check_field("total_blocks", oldest.total_blocks, out_total_blocks);
        check_field("lowest_block", oldest.lowest_block, out_lowest_block);
        check_field("end_block_plus_one", oldest.end_block_plus_one, out_end_block_plus_one);
        check_field("sum_is_hard", 64'(oldest.sum_is_hard), 64'(out_sum_is_hard));
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 120);
      end
      rx_left--;
      case (rx_mode)
        RX_OPEN:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= ((cycles % 7) < 3);
      endcase
    end
  end

  initial begin
    logic [63:0] g_start;
    logic [63:0] g_prev_start;
    logic [63:0] g_prev_end;
    logic [31:0] g_count;
    next_start_t how;
    int          list_len;
    int          flavor;
    int          lists;
    int          real_items;
    int          roll;
    clear_scan();
    lists        = 0;
    real_items   = 0;
    g_prev_start = '0;
    g_prev_end   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < PlanLen; i++) begin
      send_element(plan[i].start, plan[i].count, plan[i].last, plan[i].typed, plan[i].want);
    end
    wait_drained();

    while (real_items < RandomItems) begin
      list_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      flavor   = $urandom_range(0, 3);
      for (int k = 0; k < list_len; k++) begin
        roll = $urandom_range(0, 9);
        if (roll == 0) g_count = '0;
        else if (roll == 1) g_count = $urandom;
        else g_count = $urandom_range(1, 64);
        if (k == 0) begin
          if ($urandom_range(0, 2) == 0) g_start = {$urandom, $urandom};
          else g_start = 64'($urandom_range(0, 4096));
        end else begin
          if (flavor == 0) how = NEXT_ABUTS;
          else if (flavor == 1) how = ($urandom_range(0, 3) == 0) ? NEXT_GAP : NEXT_ABUTS;
          else how = next_start_t'($urandom_range(0, 5));
          case (how)
            NEXT_ABUTS:  g_start = g_prev_end;
            NEXT_GAP:    g_start = g_prev_end + 64'($urandom_range(1, 64));
            NEXT_SAME:   g_start = g_prev_start;
            NEXT_INSIDE: g_start = g_prev_start + 64'($urandom_range(1, 63));
            NEXT_BELOW:  g_start = g_prev_start - 64'($urandom_range(1, 64));
            default:     g_start = {$urandom, $urandom};
          endcase
        end
        if (g_count != '0 || k == 0) begin
          g_prev_start = g_start;
          g_prev_end   = g_start + 64'(g_count);
        end
        real_items++;
        send_element(g_start, g_count, k == list_len - 1, 1'b0, NoCheck);
      end
      lists++;
      if (lists == 120) wait_drained();
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
